// ===== rtl/mkdd_pkg.sv =====
// Package for the multi-key deadline debouncer.
// It holds the shared widths, codes and the debounce reset value.
// It has no dependencies and is used by the top level and its checker.
package mkdd_pkg;

    localparam int NUM_KEYS_DEF   = 48;
    localparam int TIME_WIDTH_DEF = 64;

    localparam int KEY_W   = 6;
    localparam int MASK_W  = 48;
    localparam int DEB_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic REQ_EDGE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd2;

    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 32'd5000;

endpackage

// ===== rtl/mkdd_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// It holds the per-key deadlines of the debouncer and depends on nothing else.
module mkdd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 48
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/multi_key_deadline_debouncer.sv =====
// Each request walks all keys: their deadlines are read from the deadline RAM and compared
// one per cycle. Then the keys are scanned in order and one result is registered per event,
// or a single result when there is none; the scan waits at an event while the output stalls.
// A new request is not taken until the last result of the previous one is registered.
// Reset is synchronous and active low; it clears the key states and restores the register
// defaults, while the deadline RAM is left as it is and needs no clearing pass.
module multi_key_deadline_debouncer #(
    parameter int NUM_KEYS   = mkdd_pkg::NUM_KEYS_DEF,
    parameter int TIME_WIDTH = mkdd_pkg::TIME_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mkdd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mkdd_pkg::MASK_W-1:0]    i_cfg_data,

    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_req_type,
    input  logic [mkdd_pkg::KEY_W-1:0]     i_key_index,
    input  logic [TIME_WIDTH-1:0]          i_now_time,
    input  logic [mkdd_pkg::MASK_W-1:0]    i_pin_levels,

    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_event_valid,
    output logic [mkdd_pkg::KEY_W-1:0]     o_event_key,
    output logic                           o_pressed,
    output logic                           o_alarm_armed,
    output logic [TIME_WIDTH-1:0]          o_alarm_time,
    output logic                           o_last
);

    localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int CW = $clog2(NUM_KEYS + 1);
    localparam logic [KW-1:0] LAST_KEY = KW'(NUM_KEYS - 1);
    localparam logic [mkdd_pkg::KEY_W:0] KEY_LIMIT = (mkdd_pkg::KEY_W + 1)'(NUM_KEYS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]                      r_state;
    logic [1:0]                      n_state;

    logic [mkdd_pkg::DEB_W-1:0]      r_debounce;
    logic [mkdd_pkg::MASK_W-1:0]     r_invert;
    logic [mkdd_pkg::MASK_W-1:0]     r_enable;

    logic [NUM_KEYS-1:0]             r_settling;
    logic [NUM_KEYS-1:0]             r_stable;
    logic [NUM_KEYS-1:0]             r_event;
    logic [CW-1:0]                   r_evcnt;

    logic                            r_tick;
    logic [TIME_WIDTH-1:0]           r_now;
    logic [mkdd_pkg::MASK_W-1:0]     r_pins;

    logic                            r_issue;
    logic [KW-1:0]                   r_addr;
    logic                            r_rd_vld;
    logic [KW-1:0]                   r_rd_key;
    logic [KW-1:0]                   r_scan;

    logic                            r_armed;
    logic [TIME_WIDTH-1:0]           r_earliest;

    logic                            r_out_valid;
    logic                            r_out_event;
    logic [mkdd_pkg::KEY_W-1:0]      r_out_key;
    logic                            r_out_pressed;
    logic                            r_out_armed;
    logic [TIME_WIDTH-1:0]           r_out_time;
    logic                            r_out_last;

    logic [NUM_KEYS-1:0]             key_en;
    logic [NUM_KEYS-1:0]             key_level;
    logic [TIME_WIDTH-1:0]           db_ext;
    logic [TIME_WIDTH-1:0]           rd_deadline;
    logic                            in_acc;
    logic                            in_range;
    logic                            edge_hit;
    logic                            slot_free;
    logic                            emit_go;
    logic                            live;
    logic                            expire;
    logic                            earlier;

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
        if (k < mkdd_pkg::MASK_W) begin : g_map
            assign key_en[k]    = r_enable[k];
            assign key_level[k] = r_pins[k] ^ r_invert[k];
        end else begin : g_none
            assign key_en[k]    = 1'b0;
            assign key_level[k] = 1'b0;
        end
    end

    if (TIME_WIDTH > mkdd_pkg::DEB_W) begin : g_db_pad
        assign db_ext = {{(TIME_WIDTH - mkdd_pkg::DEB_W){1'b0}}, r_debounce};
    end else if (TIME_WIDTH == mkdd_pkg::DEB_W) begin : g_db_same
        assign db_ext = r_debounce;
    end else begin : g_db_cut
        assign db_ext = r_debounce[TIME_WIDTH-1:0];
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign in_range    = ({1'b0, i_key_index} < KEY_LIMIT);
    assign edge_hit    = (i_req_type == mkdd_pkg::REQ_EDGE) && in_range
                         && key_en[i_key_index[KW-1:0]];
    assign slot_free   = !r_out_valid || i_out_ready;
    assign emit_go     = (r_state == S_EMIT) && slot_free
                         && ((r_evcnt == '0) || r_event[r_scan]);

    mkdd_ram #(
        .WIDTH (TIME_WIDTH),
        .DEPTH (NUM_KEYS)
    ) u_deadline_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && edge_hit),
        .i_waddr (i_key_index[KW-1:0]),
        .i_wdata (i_now_time + db_ext),
        .i_re    (r_issue),
        .i_raddr (r_addr),
        .o_rdata (rd_deadline)
    );

    assign live    = r_rd_vld && key_en[r_rd_key] && r_settling[r_rd_key];
    assign expire  = r_tick && !(r_now < rd_deadline);
    assign earlier = !r_armed || (rd_deadline < r_earliest);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (r_rd_vld && (r_rd_key == LAST_KEY)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (slot_free && ((r_evcnt == '0)
                    || (r_event[r_scan] && (r_evcnt == CW'(1))))) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_debounce  <= mkdd_pkg::DEBOUNCE_RESET;
            r_invert    <= '0;
            r_enable    <= '0;
            r_settling  <= '0;
            r_stable    <= '0;
            r_event     <= '0;
            r_evcnt     <= '0;
            r_issue     <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_armed     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    mkdd_pkg::CFG_DEBOUNCE: r_debounce <= i_cfg_data[mkdd_pkg::DEB_W-1:0];
                    mkdd_pkg::CFG_INVERT:   r_invert   <= i_cfg_data;
                    mkdd_pkg::CFG_ENABLE:   r_enable   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (in_acc) begin
                r_tick     <= (i_req_type == mkdd_pkg::REQ_TICK);
                r_now      <= i_now_time;
                r_pins     <= i_pin_levels;
                r_issue    <= 1'b1;
                r_addr     <= '0;
                r_armed    <= 1'b0;
                r_earliest <= '0;
                r_event    <= '0;
                r_evcnt    <= '0;
                r_scan     <= '0;
                if (edge_hit) begin
                    r_settling[i_key_index[KW-1:0]] <= 1'b1;
                end
            end

            if (r_issue) begin
                r_addr <= r_addr + KW'(1);
                if (r_addr == LAST_KEY) begin
                    r_issue <= 1'b0;
                end
            end
            r_rd_vld <= r_issue;
            r_rd_key <= r_addr;

            if (live) begin
                if (expire) begin
                    r_settling[r_rd_key] <= 1'b0;
                    if (key_level[r_rd_key] != r_stable[r_rd_key]) begin
                        r_stable[r_rd_key] <= key_level[r_rd_key];
                        r_event[r_rd_key]  <= 1'b1;
                        r_evcnt            <= r_evcnt + CW'(1);
                    end
                end else begin
                    r_armed <= 1'b1;
                    if (earlier) begin
                        r_earliest <= rd_deadline;
                    end
                end
            end

            if (r_state == S_EMIT) begin
                if (r_evcnt == '0) begin
                    if (slot_free) begin
                        r_out_event   <= 1'b0;
                        r_out_key     <= '0;
                        r_out_pressed <= 1'b0;
                        r_out_armed   <= r_armed;
                        r_out_time    <= r_armed ? r_earliest : '0;
                        r_out_last    <= 1'b1;
                    end
                end else if (r_event[r_scan]) begin
                    if (slot_free) begin
                        r_out_event      <= 1'b1;
                        r_out_key        <= mkdd_pkg::KEY_W'(r_scan);
                        r_out_pressed    <= r_stable[r_scan];
                        r_out_armed      <= r_armed;
                        r_out_time       <= r_armed ? r_earliest : '0;
                        r_out_last       <= (r_evcnt == CW'(1));
                        r_event[r_scan]  <= 1'b0;
                        r_evcnt          <= r_evcnt - CW'(1);
                        r_scan           <= r_scan + KW'(1);
                    end
                end else begin
                    r_scan <= r_scan + KW'(1);
                end
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_valid = r_out_event;
    assign o_event_key   = r_out_key;
    assign o_pressed     = r_out_pressed;
    assign o_alarm_armed = r_out_armed;
    assign o_alarm_time  = r_out_time;
    assign o_last        = r_out_last;

endmodule

// ===== rtl/mkdd_checker.sv =====
// Port-level checker for the multi-key deadline debouncer.
// It sees only the top level's ports, takes its widths from the package, and is bound to it at the end of this file.
module mkdd_checker #(
    parameter int NUM_KEYS   = mkdd_pkg::NUM_KEYS_DEF,
    parameter int TIME_WIDTH = mkdd_pkg::TIME_WIDTH_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic                       o_event_valid,
    input logic [mkdd_pkg::KEY_W-1:0] o_event_key,
    input logic                       o_alarm_armed,
    input logic [TIME_WIDTH-1:0]      o_alarm_time,
    input logic                       o_last
);

    localparam logic [mkdd_pkg::KEY_W:0] KEY_LIMIT = (mkdd_pkg::KEY_W + 1)'(NUM_KEYS);

    // A request occupies the block, so it cannot take another in the next cycle.
    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken on the cycle after a request");

    a_quiet_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_alarm_armed |-> o_alarm_time == '0)
        else $error("alarm time reported while the alarm is not armed");

    a_null_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_event_valid |-> o_last)
        else $error("result without an event is not the last of its request");

    a_key_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_valid |-> ({1'b0, o_event_key} < KEY_LIMIT))
        else $error("event reported for a key beyond the key count");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_event_key)
        && $stable(o_last))
        else $error("stalled result changed before it was taken");

endmodule

bind multi_key_deadline_debouncer mkdd_checker #(
    .NUM_KEYS   (NUM_KEYS),
    .TIME_WIDTH (TIME_WIDTH)
) u_mkdd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_event_valid (o_event_valid),
    .o_event_key   (o_event_key),
    .o_alarm_armed (o_alarm_armed),
    .o_alarm_time  (o_alarm_time),
    .o_last        (o_last)
);
